// File: hw/rtl/fsa_pkg.sv
// Shared types, constants and saturation helpers of the full-Stokes accumulator.
package fsa_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_BINS_W = 13;
	localparam int NUM_SPECTRA_W = 16;
	localparam int BIN_INDEX_W = 12;
	localparam int OUT_W = 272;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SPECTRA = 2'd1;

	localparam logic [62:0] POW_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	// One bin's four sums, also used for the per-item terms.
	typedef struct packed {
		logic signed [63:0] ci;
		logic signed [63:0] cr;
		logic [62:0] py;
		logic [62:0] px;
	} fsa_sums_t;

	// Clamp a non-negative 65-bit value to the power range.
	function automatic logic [62:0] sat_pow(input logic [64:0] v);
		return (v[64:63] != 2'b00) ? POW_MAX : v[62:0];
	endfunction

	// Clamp a signed 65-bit value to the signed 64-bit range.
	function automatic logic [63:0] sat_s64(input logic signed [64:0] v);
		if (v[64] != v[63]) begin
			return v[64] ? S64_MIN : S64_MAX;
		end
		return v[63:0];
	endfunction

endpackage

// File: hw/rtl/fsa_terms.sv
// Two-stage product and per-item Stokes term pipeline.
module fsa_terms import fsa_pkg::*; #(
	parameter int SB = 24
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [SB-1:0] x_re,
	input  logic signed [SB-1:0] x_im,
	input  logic signed [SB-1:0] y_re,
	input  logic signed [SB-1:0] y_im,
	output fsa_sums_t            terms_s2
);

	localparam int PW = 2 * SB;

	logic signed [PW-1:0] xrxr_s1, xixi_s1, yryr_s1, yiyi_s1;
	logic signed [PW-1:0] xryr_s1, xiyi_s1, xiyr_s1, xryi_s1;
	logic signed [64:0] px_sum, py_sum, cr_sum, ci_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			xrxr_s1 <= x_re * x_re;
			xixi_s1 <= x_im * x_im;
			yryr_s1 <= y_re * y_re;
			yiyi_s1 <= y_im * y_im;
			xryr_s1 <= x_re * y_re;
			xiyi_s1 <= x_im * y_im;
			xiyr_s1 <= x_im * y_re;
			xryi_s1 <= x_re * y_im;
		end
	end

	always_comb begin
		px_sum = 65'(xrxr_s1) + 65'(xixi_s1);
		py_sum = 65'(yryr_s1) + 65'(yiyi_s1);
		cr_sum = 65'(xryr_s1) + 65'(xiyi_s1);
		ci_sum = 65'(xiyr_s1) - 65'(xryi_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			terms_s2.px <= sat_pow(px_sum);
			terms_s2.py <= sat_pow(py_sum);
			terms_s2.cr <= sat_s64(cr_sum);
			terms_s2.ci <= sat_s64(ci_sum);
		end
	end

endmodule

// File: hw/rtl/fsa_store.sv
// Per-bin sum memory with registered read and a clearing sweep after reset.
module fsa_store import fsa_pkg::*; #(
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output fsa_sums_t                rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  fsa_sums_t                wr_data,
	output logic                     busy
);

	localparam int AW = $clog2(DEPTH);

	fsa_sums_t mem [DEPTH];
	logic clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic mem_we;
	logic [AW-1:0] mem_addr;
	fsa_sums_t mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		mem_we = clearing_q | wr_en;
		mem_addr = clearing_q ? clr_addr_q : wr_addr;
		mem_wdata = clearing_q ? '0 : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = clearing_q;

endmodule

// File: hw/rtl/full_stokes_spectral_accumulator.sv
// Full-Stokes accumulator: one dual-pol bin per item, sums four Stokes terms per bin.
// An item passes stage 1, stage 2 and the output register before its result is valid.
// Throughput: one item per cycle unless stalled; memory read and write once per cycle.
// Output backpressure stalls the whole pipeline until the held result is taken.
// After reset a sweep zeroes all MAX_BINS memory entries; no item is accepted then.
// Reset sets num_bins to 4096, num_spectra to 1 and both counters to zero.
module full_stokes_spectral_accumulator import fsa_pkg::*; #(
	parameter int MAX_BINS = 4096,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// x_re, x_im, y_re, y_im (SAMPLE_BITS each), zero pad to whole bytes
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// bin_index[11:0], power_x[74:12], power_y[137:75], cross_re[201:138],
	// cross_im[265:202], zero pad
	output logic [OUT_W-1:0]       m_tdata,
	output logic                   m_tlast
);

	localparam int SB = SAMPLE_BITS;
	localparam int IDX_W = $clog2(MAX_BINS);
	localparam int CMP_W = ((IDX_W > NUM_BINS_W) ? IDX_W : NUM_BINS_W) + 1;
	localparam int NS_W = NUM_SPECTRA_W + 1;

	typedef struct packed {
		logic [IDX_W-1:0] bin;
		logic last_b;
		logic last_s;
	} tag_t;

	logic [NUM_BINS_W-1:0] num_bins_q;
	logic [NUM_SPECTRA_W-1:0] num_spectra_q;
	logic [IDX_W-1:0] bin_cnt_q;
	logic [NUM_SPECTRA_W-1:0] spec_cnt_q;

	logic en, busy, accept;
	logic [CMP_W-1:0] nb_eff;
	logic [NS_W-1:0] ns_eff;
	logic last_b, last_s;

	logic v_s1, v_s2;
	tag_t tag_s1, tag_s2;
	fsa_sums_t terms_s2, rd_data, base, new_sums, wr_data;

	logic fwd_v_q;
	logic [IDX_W-1:0] fwd_bin_q;
	fsa_sums_t fwd_q;

	logic out_valid_q;
	tag_t out_tag_q;
	fsa_sums_t out_sums_q;
	logic [31:0] bin_wide;

	assign en = !out_valid_q || m_tready;
	assign s_tready = en && !busy;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q <= NUM_BINS_W'(4096);
			num_spectra_q <= NUM_SPECTRA_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_BINS: num_bins_q <= cfg_data[NUM_BINS_W-1:0];
				REG_NUM_SPECTRA: num_spectra_q <= cfg_data[NUM_SPECTRA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nb_eff = CMP_W'(num_bins_q);
		if (nb_eff == '0) begin
			nb_eff = CMP_W'(1);
		end
		if (nb_eff > CMP_W'(MAX_BINS)) begin
			nb_eff = CMP_W'(MAX_BINS);
		end
		ns_eff = NS_W'(num_spectra_q);
		if (ns_eff == '0) begin
			ns_eff = NS_W'(1);
		end
		last_b = (CMP_W'(bin_cnt_q) + CMP_W'(1)) >= nb_eff;
		last_s = (NS_W'(spec_cnt_q) + NS_W'(1)) >= ns_eff;
	end

	// Advance the bin and spectrum counters on each accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q <= '0;
			spec_cnt_q <= '0;
		end else if (accept) begin
			if (last_b) begin
				bin_cnt_q <= '0;
				spec_cnt_q <= last_s ? '0 : spec_cnt_q + NUM_SPECTRA_W'(1);
			end else begin
				bin_cnt_q <= bin_cnt_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= '{bin: bin_cnt_q, last_b: last_b, last_s: last_s};
			tag_s2 <= tag_s1;
		end
	end

	fsa_terms #(.SB(SB)) u_terms (
		.clk      (clk),
		.en       (en),
		.x_re     (s_tdata[SB-1:0]),
		.x_im     (s_tdata[2*SB-1:SB]),
		.y_re     (s_tdata[3*SB-1:2*SB]),
		.y_im     (s_tdata[4*SB-1:3*SB]),
		.terms_s2 (terms_s2)
	);

	fsa_store #(.DEPTH(MAX_BINS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (en),
		.rd_addr (tag_s1.bin),
		.rd_data (rd_data),
		.wr_en   (en && v_s2),
		.wr_addr (tag_s2.bin),
		.wr_data (wr_data),
		.busy    (busy)
	);

	// The read for stage 2 raced the write of the item ahead; take that write instead.
	always_comb begin
		base = (fwd_v_q && fwd_bin_q == tag_s2.bin) ? fwd_q : rd_data;
		new_sums.px = sat_pow({2'b00, base.px} + {2'b00, terms_s2.px});
		new_sums.py = sat_pow({2'b00, base.py} + {2'b00, terms_s2.py});
		new_sums.cr = sat_s64(65'(base.cr) + 65'(terms_s2.cr));
		new_sums.ci = sat_s64(65'(base.ci) + 65'(terms_s2.ci));
		wr_data = tag_s2.last_s ? '0 : new_sums;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			fwd_v_q <= v_s2;
			out_valid_q <= v_s2 && tag_s2.last_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_bin_q <= tag_s2.bin;
			fwd_q <= wr_data;
			out_tag_q <= tag_s2;
			out_sums_q <= new_sums;
		end
	end

	assign bin_wide = 32'(out_tag_q.bin);
	assign m_tvalid = out_valid_q;
	assign m_tlast = out_tag_q.last_b;
	assign m_tdata = {6'b0, out_sums_q.ci, out_sums_q.cr, out_sums_q.py, out_sums_q.px,
		bin_wide[BIN_INDEX_W-1:0]};

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !v_s1 && !v_s2 && !out_valid_q)
		else $error("pipeline not empty during memory clear");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> $stable(bin_cnt_q) && $stable(spec_cnt_q))
		else $error("counters moved without an accepted item");

	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s2 && tag_s2.last_s |=> out_valid_q)
		else $error("emitting item did not reach the output");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bin_cnt_q) < 32'(MAX_BINS))
		else $error("bin counter beyond memory depth");

endmodule
